// File: rtl/float_triple_run_scanner_macros.svh
// ----------------------------------------------------------------------------
// float_triple_run_scanner assertion macros
// shared assertion forms, clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef FLOAT_TRIPLE_RUN_SCANNER_MACROS_SVH
`define FLOAT_TRIPLE_RUN_SCANNER_MACROS_SVH

// condition holds at every edge out of reset
`define FTRS_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define FTRS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define FTRS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ftrs_pkg.sv
// ----------------------------------------------------------------------------
// ftrs_pkg
// types, constants and the word classifier shared by the run scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ftrs_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned IdxW      = 30;
  localparam int unsigned CntW      = 31;
  localparam int unsigned QueueDepth = 4;

  localparam logic [WordW-1:0] AbsEight = 32'h4100_0000;
  localparam logic [WordW-1:0] AbsInf   = 32'h7F80_0000;
  localparam logic [IdxW-1:0]  IdxMax   = {IdxW{1'b1}};
  localparam logic [CntW-1:0]  CntMax   = {CntW{1'b1}};

  // classified word moving from front to back
  typedef struct packed {
    logic last;
    logic nonzero;
    logic sane;
  } item_t;

  typedef struct packed {
    logic            run_valid;
    logic [WordW-1:0] run_offset;
    logic [CntW-1:0] run_count;
    logic            done_res;
    logic [CntW-1:0] total_runs;
  } result_t;

  // in [-8,8] or nan counts as sane; +0 and -0 are zero
  function automatic item_t classify(input logic [WordW-1:0] word, input logic last);
    logic [WordW-1:0] mag;
    item_t it;
    mag        = {1'b0, word[WordW-2:0]};
    it.sane    = (mag <= AbsEight) || (mag > AbsInf);
    it.nonzero = (mag != '0);
    it.last    = last;
    return it;
  endfunction

  function automatic logic [CntW-1:0] sat_inc_cnt(input logic [CntW-1:0] v);
    return (v != CntMax) ? v + 1'b1 : v;
  endfunction

  function automatic logic [IdxW-1:0] sat_inc_idx(input logic [IdxW-1:0] v);
    return (v != IdxMax) ? v + 1'b1 : v;
  endfunction

endpackage

// File: rtl/float_triple_run_scanner.sv
// Accepts one word per cycle while full is low; ftrs_back updates its scan state per item.
// A result reaches the output queue after its word passes the front queue and ftrs_back.
// Front and back queues are QueueDepth entries each and decouple input and output stalls.
// Reset (async, active low) clears the scan state, both queues and min_run; no clearing pass.
// ----------------------------------------------------------------------------
// float_triple_run_scanner
// finds runs of sane float triples in a word stream and reports them
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module float_triple_run_scanner #(
  parameter int unsigned QueueDepth = ftrs_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ftrs_pkg::CntW-1:0]   cfg_wdata_i,
  input  logic                        push,
  output logic                        full,
  input  logic [ftrs_pkg::WordW-1:0]  word_i,
  input  logic                        last_i,
  output logic                        empty,
  input  logic                        pop,
  output logic                        run_valid_o,
  output logic [ftrs_pkg::WordW-1:0]  run_offset_o,
  output logic [ftrs_pkg::CntW-1:0]   run_count_o,
  output logic                        done_res_o,
  output logic [ftrs_pkg::CntW-1:0]   total_runs_o
);

  import ftrs_pkg::*;

  logic [CntW-1:0] min_run_q;
  logic            item_valid, item_ready, res_full, res_push;
  item_t           item;
  result_t         res_in, res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_run_q <= '0;
    end else if (cfg_we_i) begin
      min_run_q <= cfg_wdata_i;
    end
  end

  ftrs_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .word_i       (word_i),
    .last_i       (last_i),
    .full_o       (full),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  ftrs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .min_run_i    (min_run_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  ftrs_fifo #(
    .Width ($bits(result_t)),
    .Depth (QueueDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign run_valid_o  = res_out.run_valid;
  assign run_offset_o = res_out.run_offset;
  assign run_count_o  = res_out.run_count;
  assign done_res_o   = res_out.done_res;
  assign total_runs_o = res_out.total_runs;

endmodule

// File: rtl/ftrs_fifo.sv
// ----------------------------------------------------------------------------
// ftrs_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftrs_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = ftrs_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NumW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NumW-1:0]  num_q, num_d;
  logic             do_push, do_pop;

  assign full_o  = (num_q == NumW'(Depth));
  assign empty_o = (num_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    num_d  = num_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      num_d = num_q + 1'b1;
    end else if (do_pop && !do_push) begin
      num_d = num_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      num_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      num_q  <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/ftrs_front.sv
// ----------------------------------------------------------------------------
// ftrs_front
// classifies incoming words and queues the flags for the scan engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftrs_front #(
  parameter int unsigned Depth = ftrs_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [ftrs_pkg::WordW-1:0]   word_i,
  input  logic                         last_i,
  output logic                         full_o,
  output logic                         item_valid_o,
  output ftrs_pkg::item_t              item_o,
  input  logic                         item_ready_i
);

  import ftrs_pkg::*;

  item_t cls;
  logic  q_empty;

  assign cls          = classify(word_i, last_i);
  assign item_valid_o = !q_empty;

  ftrs_fifo #(
    .Width ($bits(item_t)),
    .Depth (Depth)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cls),
    .full_o  (full_o),
    .pop_i   (item_ready_i),
    .data_o  (item_o),
    .empty_o (q_empty)
  );

endmodule

// File: rtl/ftrs_back.sv
// ----------------------------------------------------------------------------
// ftrs_back
// scan engine: tracks windows and triples, closes runs, builds results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "float_triple_run_scanner_macros.svh"

module ftrs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ftrs_pkg::CntW-1:0]  min_run_i,
  input  logic                       item_valid_i,
  input  ftrs_pkg::item_t            item_i,
  output logic                       item_ready_o,
  input  logic                       res_full_i,
  output logic                       res_push_o,
  output ftrs_pkg::result_t          res_o
);

  import ftrs_pkg::*;

  logic [3:0]      prev_flags_q, prev_flags_d;
  logic [IdxW-1:0] word_index_q, word_index_d;
  logic            in_run_q, in_run_d;
  logic [1:0]      phase_q, phase_d;
  logic [IdxW-1:0] run_start_q, run_start_d;
  logic [CntW-1:0] run_triples_q, run_triples_d;
  logic [CntW-1:0] found_q, found_d;

  logic step, all_sane, any_nz, close_run, report;

  assign item_ready_o = !res_full_i;
  assign step         = item_valid_i && !res_full_i;

  // prev_flags: [1:0] previous word {nz, sane}, [3:2] the one before
  assign all_sane = item_i.sane && prev_flags_q[0] && prev_flags_q[2];
  assign any_nz   = item_i.nonzero || prev_flags_q[1] || prev_flags_q[3];

  always_comb begin
    prev_flags_d  = prev_flags_q;
    word_index_d  = word_index_q;
    in_run_d      = in_run_q;
    phase_d       = phase_q;
    run_start_d   = run_start_q;
    run_triples_d = run_triples_q;
    found_d       = found_q;
    close_run     = 1'b0;
    report        = 1'b0;
    res_o         = '0;
    res_push_o    = 1'b0;
    if (step) begin
      if (in_run_q) begin
        if (phase_q == 2'd2) begin
          if (all_sane) begin
            run_triples_d = sat_inc_cnt(run_triples_q);
            phase_d       = 2'd0;
          end else begin
            close_run = 1'b1;
          end
        end else begin
          phase_d = phase_q + 1'b1;
        end
      end else if (word_index_q >= IdxW'(2)) begin
        if (all_sane && any_nz) begin
          in_run_d      = 1'b1;
          run_start_d   = word_index_q - IdxW'(2);
          run_triples_d = '0;
          phase_d       = 2'd0;
        end
      end

      if (in_run_d && item_i.last) begin
        close_run = 1'b1;
      end

      if (close_run) begin
        if (run_triples_d >= min_run_i) begin
          report          = 1'b1;
          res_o.run_offset = {run_start_d, 2'b00};
          res_o.run_count  = run_triples_d;
          found_d          = sat_inc_cnt(found_q);
        end
        in_run_d      = 1'b0;
        phase_d       = 2'd0;
        run_triples_d = '0;
      end

      prev_flags_d     = {prev_flags_q[1:0], item_i.nonzero, item_i.sane};
      word_index_d     = sat_inc_idx(word_index_q);
      res_o.run_valid  = report;
      res_o.done_res   = item_i.last;
      res_o.total_runs = found_d;
      res_push_o       = report || item_i.last;

      // end of buffer: next word starts a fresh stream
      if (item_i.last) begin
        prev_flags_d  = '0;
        word_index_d  = '0;
        in_run_d      = 1'b0;
        phase_d       = 2'd0;
        run_start_d   = '0;
        run_triples_d = '0;
        found_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_flags_q  <= '0;
      word_index_q  <= '0;
      in_run_q      <= 1'b0;
      phase_q       <= 2'd0;
      run_start_q   <= '0;
      run_triples_q <= '0;
      found_q       <= '0;
    end else begin
      prev_flags_q  <= prev_flags_d;
      word_index_q  <= word_index_d;
      in_run_q      <= in_run_d;
      phase_q       <= phase_d;
      run_start_q   <= run_start_d;
      run_triples_q <= run_triples_d;
      found_q       <= found_d;
    end
  end

  `FTRS_ASSERT_ALWAYS(a_phase_range, phase_q != 2'd3, "triple phase out of range")
  `FTRS_ASSERT_IMPL(a_idle_clean, !in_run_q, (phase_q == 2'd0) && (run_triples_q == '0),
                    "run state left behind outside a run")
  `FTRS_ASSERT_NEXT(a_last_clears, step && item_i.last,
                    !in_run_q && (word_index_q == '0) && (found_q == '0),
                    "stream state not cleared after last word")
  `FTRS_ASSERT_IMPL(a_run_needs_words, in_run_q, word_index_q >= IdxW'(3),
                    "run open before three words seen")

endmodule

// File: tb/float_triple_run_scanner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_triple_run_scanner_tb
// streams float word buffers through the run scanner, predicts each run
// report and end-of-buffer total, and checks them against the output queue
// with and without random idling on both sides and under several min_run settings
// ----------------------------------------------------------------------------

module float_triple_run_scanner_tb;
  import ftrs_pkg::*;

  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned MaxShown      = 10;

  localparam logic [30:0] MagEight = 31'h4100_0000;
  localparam logic [30:0] MagInf   = 31'h7F80_0000;
  localparam logic [CntW-1:0] MinRunTop = 31'd1431655765;
  localparam logic [CntW-1:0] MinRunAlt = 31'h2AAA_AAAA;

  typedef enum logic [2:0] {
    WordSaneNz,
    WordZero,
    WordNan,
    WordWild,
    WordAny
  } word_kind_e;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CntW-1:0]  cfg_wdata_i = '0;
  logic             push        = 1'b0;
  logic             full;
  logic [WordW-1:0] word_i      = '0;
  logic             last_i      = 1'b0;
  logic             empty;
  logic             pop         = 1'b0;
  logic             run_valid_o;
  logic [WordW-1:0] run_offset_o;
  logic [CntW-1:0]  run_count_o;
  logic             done_res_o;
  logic [CntW-1:0]  total_runs_o;

  // scan state mirrored by the predictor
  logic [3:0]      scan_prev_flags = '0;
  logic [IdxW-1:0] scan_word_idx   = '0;
  logic            scan_in_run     = 1'b0;
  logic [1:0]      scan_phase      = '0;
  logic [IdxW-1:0] scan_run_first  = '0;
  logic [CntW-1:0] scan_run_len    = '0;
  logic [CntW-1:0] scan_found      = '0;
  logic [CntW-1:0] min_run_q       = '0;

  result_t pending_reports[$];
  result_t want;

  int unsigned words_sent   = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles  = 0;
  int unsigned rx_hold      = 0;
  bit          tx_idle_en   = 1'b1;
  bit          rx_idle_en   = 1'b1;

  float_triple_run_scanner u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .word_i       (word_i),
    .last_i       (last_i),
    .empty        (empty),
    .pop          (pop),
    .run_valid_o  (run_valid_o),
    .run_offset_o (run_offset_o),
    .run_count_o  (run_count_o),
    .done_res_o   (done_res_o),
    .total_runs_o (total_runs_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [CntW-1:0] count_up(input logic [CntW-1:0] v);
    return (v != '1) ? v + 1'b1 : v;
  endfunction

  // advance the scan by one word and queue the result it causes, if any
  task automatic predict_word(input logic [WordW-1:0] w, input logic is_last);
    logic [30:0] mag;
    logic [1:0]  cur;
    logic [1:0]  p1;
    logic [1:0]  p2;
    logic        closing;
    logic        reporting;
    result_t     res;
    mag       = w[30:0];
    cur[0]    = (mag <= MagEight) || (mag > MagInf);
    cur[1]    = (mag != '0);
    p1        = scan_prev_flags[1:0];
    p2        = scan_prev_flags[3:2];
    closing   = 1'b0;
    reporting = 1'b0;
    res       = '0;
    if (scan_in_run) begin
      if (scan_phase >= 2'd2) begin
        if (cur[0] && p1[0] && p2[0]) begin
          scan_run_len = count_up(scan_run_len);
          scan_phase   = '0;
        end else begin
          closing = 1'b1;
        end
      end else begin
        scan_phase = scan_phase + 1'b1;
      end
    end else if (scan_word_idx >= 2) begin
      if ((cur[0] && p1[0] && p2[0]) && (cur[1] || p1[1] || p2[1])) begin
        scan_in_run    = 1'b1;
        scan_run_first = scan_word_idx - 2'd2;
        scan_run_len   = '0;
        scan_phase     = '0;
      end
    end
    if (scan_in_run && is_last) closing = 1'b1;
    if (closing) begin
      if (scan_run_len >= min_run_q) begin
        reporting      = 1'b1;
        res.run_valid  = 1'b1;
        res.run_offset = {scan_run_first, 2'b00};
        res.run_count  = scan_run_len;
        scan_found     = count_up(scan_found);
      end
      scan_in_run  = 1'b0;
      scan_phase   = '0;
      scan_run_len = '0;
    end
    scan_prev_flags = {scan_prev_flags[1:0], cur};
    if (scan_word_idx != '1) scan_word_idx = scan_word_idx + 1'b1;
    if (reporting || is_last) begin
      res.done_res   = is_last;
      res.total_runs = scan_found;
      pending_reports.push_back(res);
    end
    if (is_last) begin
      scan_prev_flags = '0;
      scan_word_idx   = '0;
      scan_in_run     = 1'b0;
      scan_phase      = '0;
      scan_run_first  = '0;
      scan_run_len    = '0;
      scan_found      = '0;
    end
  endtask

  task automatic send_word(input logic [WordW-1:0] w, input logic is_last);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    push   <= 1'b1;
    word_i <= w;
    last_i <= is_last;
    do @(posedge clk_i); while (full);
    predict_word(w, is_last);
    words_sent++;
  endtask

  // block is idle once every result is out and words with no result have drained
  task automatic drain_scanner();
    push <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_min_run(input logic [CntW-1:0] v);
    drain_scanner();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    min_run_q   = v;
  endtask

  function automatic logic [WordW-1:0] rand_word(input word_kind_e kind);
    logic [30:0] mag;
    case (kind)
      WordSaneNz: mag = 31'($urandom_range(1, 32'h4100_0000));
      WordZero:   mag = '0;
      WordNan:    mag = 31'($urandom_range(32'h7F80_0001, 32'h7FFF_FFFF));
      WordWild:   mag = 31'($urandom_range(32'h4100_0001, 32'h7F80_0000));
      default:    return $urandom();
    endcase
    return {1'($urandom_range(0, 1)), mag};
  endfunction

  function automatic word_kind_e pick_kind(input bit noisy);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (noisy) return (r < 60) ? WordAny : (r < 80) ? WordWild : (r < 90) ? WordZero : WordNan;
    if (r < 55) return WordSaneNz;
    if (r < 70) return WordZero;
    if (r < 76) return WordNan;
    if (r < 86) return WordWild;
    return WordAny;
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(1, 3);
    if (r < 85) return $urandom_range(4, 30);
    return $urandom_range(31, 90);
  endfunction

  task automatic send_buffer(input int unsigned len, input bit noisy, input bit close_it);
    for (int unsigned i = 0; i < len; i++) begin
      send_word(rand_word(pick_kind(noisy)), close_it && (i == len - 1));
    end
  endtask

  task automatic test_directed();
    set_min_run('0);
    // single word and two-word buffers never start a run
    send_word(32'h3F80_0000, 1'b1);
    send_word(32'h4100_0000, 1'b0);
    send_word(32'hC100_0000, 1'b1);
    // zero window, nan start, failing triple, then a run opened on the last word
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h7FC0_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h4100_0000, 1'b0);
    send_word(32'h4100_0001, 1'b0);
    send_word(32'h7F80_0000, 1'b0);
    send_word(32'h0080_0000, 1'b0);
    send_word(32'hBF80_0000, 1'b0);
    send_word(32'h3F00_0000, 1'b1);
    // long run left with an incomplete triple at the end of the buffer
    for (int i = 0; i < 11; i++) begin
      send_word((i % 2 == 0) ? 32'hC100_0000 : 32'h7F80_0001, i == 10);
    end
  endtask

  task automatic test_min_run_settings();
    logic [CntW-1:0] settings[6];
    settings = '{31'd1, 31'd2, MinRunTop, 31'd3, MinRunAlt, 31'($urandom_range(0, 5))};
    foreach (settings[s]) begin
      set_min_run(settings[s]);
      repeat (2) send_buffer(pick_len(), 1'b0, 1'b1);
    end
  endtask

  // a config write that lands in the middle of a buffer
  task automatic test_config_mid_buffer();
    set_min_run('0);
    send_buffer(14, 1'b0, 1'b0);
    set_min_run(31'd1);
    send_buffer(16, 1'b0, 1'b1);
  endtask

  task automatic test_random_streams();
    int unsigned stop_at;
    stop_at = words_sent + 700;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) set_min_run(31'($urandom_range(0, 3)));
      send_buffer(pick_len(), $urandom_range(0, 4) == 0, $urandom_range(0, 9) != 0);
    end
  endtask

  task automatic test_full_rate();
    int unsigned stop_at;
    set_min_run('0);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    stop_at    = words_sent + 150;
    while (words_sent < stop_at) send_buffer(pick_len(), 1'b0, 1'b1);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_min_run_settings();
    test_config_mid_buffer();
    test_random_streams();
    test_full_rate();
    drain_scanner();
    if (mismatch_cnt == 0 && pending_reports.size() == 0) begin
      $display("** float_triple_run_scanner: PASSED **");
    end else begin
      $display("** float_triple_run_scanner: FAILED **");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      pop     <= 1'b0;
      rx_hold <= $urandom_range(0, 13);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_reports.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxShown) begin
          $display("%t: unexpected transaction valid=%0b off=%0h cnt=%0d done=%0b total=%0d",
                   $realtime, run_valid_o, run_offset_o, run_count_o, done_res_o,
                   total_runs_o);
        end
      end else begin
        want = pending_reports.pop_front();
        if (run_valid_o !== want.run_valid || run_offset_o !== want.run_offset ||
            run_count_o !== want.run_count || done_res_o !== want.done_res ||
            total_runs_o !== want.total_runs) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxShown) begin
            $display("%t: mismatch exp valid=%0b off=%0h cnt=%0d done=%0b total=%0d",
                     $realtime, want.run_valid, want.run_offset, want.run_count,
                     want.done_res, want.total_runs);
            $display("%t:          got valid=%0b off=%0h cnt=%0d done=%0b total=%0d",
                     $realtime, run_valid_o, run_offset_o, run_count_o, done_res_o,
                     total_runs_o);
          end
        end
      end
    end
  end

  // any accepted transaction on either side resets the count
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("** float_triple_run_scanner: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: files.f
+incdir+rtl
rtl/ftrs_pkg.sv
rtl/ftrs_fifo.sv
rtl/ftrs_front.sv
rtl/ftrs_back.sv
rtl/float_triple_run_scanner.sv
tb/float_triple_run_scanner_tb.sv
